>>> rtl/core/u8cf_pkg.sv
// Shared types and constants for the UTF-8 stream decoder with case mapping.
package u8cf_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] STAR_UNIT = 16'h002A;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_WIDE    = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   localparam logic [1:0] CASE_NONE  = 2'd0;
   localparam logic [1:0] CASE_LOWER = 2'd1;
   localparam logic [1:0] CASE_UPPER = 2'd2;

   typedef struct packed {
      logic [15:0] code_unit;
      logic [1:0]  status;
      logic [1:0]  seq_length;
   } unit_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_ctrl_type;

endpackage

>>> rtl/core/u8cf_front.sv
// Front part: accepts stream bytes and assembles decoded code units.
module u8cf_front
   import u8cf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  logic [7:0] req_in_byte,
   input  logic     queue_full,
   output logic     push,
   output unit_type push_data
);

   logic [1:0]  remain_ff, remain_in;
   logic [1:0]  total_ff, total_in;
   logic [15:0] partial_ff, partial_in;
   logic [15:0] folded;
   logic        accept;
   logic        emit;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign folded    = {partial_ff[9:0], 6'b0} + {8'b0, req_in_byte} - 16'h0080;

   always_comb begin
      remain_in  = remain_ff;
      total_in   = total_ff;
      partial_in = partial_ff;
      emit       = 1'b0;
      push_data  = '{code_unit: STAR_UNIT, status: STATUS_INVALID, seq_length: 2'd1};
      if (remain_ff != 2'd0) begin
         partial_in = folded;
         remain_in  = remain_ff - 2'd1;
         emit       = (remain_ff == 2'd1);
         push_data  = '{code_unit: folded, status: STATUS_OK, seq_length: total_ff};
      end else begin
         case (req_in_byte) inside
            [8'h00:8'h7F]: begin
               total_in  = 2'd1;
               emit      = 1'b1;
               push_data = '{code_unit: {8'b0, req_in_byte}, status: STATUS_OK,
                             seq_length: 2'd1};
            end
            [8'hC0:8'hDF]: begin
               partial_in = {11'b0, req_in_byte[4:0]};
               remain_in  = 2'd1;
               total_in   = 2'd2;
            end
            [8'hE0:8'hEF]: begin
               partial_in = {12'b0, req_in_byte[3:0]};
               remain_in  = 2'd2;
               total_in   = 2'd3;
            end
            [8'hF0:8'hFD]: begin
               total_in  = 2'd1;
               emit      = 1'b1;
               push_data = '{code_unit: STAR_UNIT, status: STATUS_WIDE, seq_length: 2'd1};
            end
            default: begin
               total_in  = 2'd1;
               emit      = 1'b1;
            end
         endcase
      end
   end

   assign push = accept && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= 2'd0;
         total_ff  <= 2'd0;
      end else if (accept) begin
         remain_ff <= remain_in;
         total_ff  <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         partial_ff <= partial_in;
      end
   end

endmodule

>>> rtl/core/u8cf_queue.sv
// Short queue of decoded units between the front and back parts.
module u8cf_queue
   import u8cf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  unit_type       push_data,
   input  logic           pop,
   output queue_ctrl_type ctrl,
   output unit_type       pop_data
);

   unit_type                mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;

   assign ctrl.valid = (count_ff != '0);
   assign ctrl.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_data   = mem[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/u8cf_back.sv
// Back part: applies the case mapping and holds the result register.
module u8cf_back
   import u8cf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic [1:0]     case_mode,
   input  queue_ctrl_type ctrl,
   input  unit_type       pop_data,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic [15:0]    rsp_code_unit,
   output logic [1:0]     rsp_status,
   output logic [1:0]     rsp_seq_length
);

   function automatic logic [15:0] map_lower(input logic [15:0] u);
      logic odd;
      odd = u[0];
      if (u inside {[16'h0041:16'h005A], [16'h00C0:16'h00DE]}) begin
         return u + 16'h0020;
      end else if ((u inside {[16'h0100:16'h0137], [16'h014A:16'h0177]} && !odd) ||
                   (u inside {[16'h0139:16'h0148], [16'h0179:16'h017E]} && odd)) begin
         return u + 16'h0001;
      end else if (u == 16'h0178) begin
         return 16'h00FF;
      end
      return u;
   endfunction

   function automatic logic [15:0] map_upper(input logic [15:0] u);
      logic odd;
      odd = u[0];
      if (u inside {[16'h0061:16'h007A], [16'h00E0:16'h00FE]}) begin
         return u - 16'h0020;
      end else if ((u inside {[16'h0100:16'h0137], [16'h014A:16'h0177]} && odd) ||
                   (u inside {[16'h0139:16'h0148], [16'h0179:16'h017E]} && !odd)) begin
         return u - 16'h0001;
      end else if (u == 16'h00FF) begin
         return 16'h0178;
      end
      return u;
   endfunction

   logic        valid_ff;
   unit_type    out_ff, out_in;

   assign pop = ctrl.valid && (!valid_ff || !rsp_stall);

   always_comb begin
      out_in = pop_data;
      case (case_mode)
         CASE_LOWER: out_in.code_unit = map_lower(pop_data.code_unit);
         CASE_UPPER: out_in.code_unit = map_upper(pop_data.code_unit);
         default:    out_in.code_unit = pop_data.code_unit;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_code_unit  = out_ff.code_unit;
   assign rsp_status     = out_ff.status;
   assign rsp_seq_length = out_ff.seq_length;

endmodule

>>> rtl/core/utf8_stream_decoder_case_fold.sv
// Top level of the UTF-8 byte stream decoder with optional Latin case mapping.
//
// The request channel takes one UTF-8 byte per transfer on req_in_byte.
// The response channel gives one 16-bit code unit with its status and the
// number of bytes it consumed. A lead byte of a two- or three-byte sequence
// gives no response; the last byte of the sequence does.
// The front part decodes the byte in the cycle of its transfer and writes
// the unit into a two-entry queue; the back part maps the case and loads the
// output register. rsp_valid rises once the unit has been written into the
// queue and then loaded into the output register. One byte is taken every
// cycle while the response side keeps up.
// When the receiver stalls, the output register holds, the queue fills and
// req_stall rises once both queue entries are taken.
// csr_wr_data selects no change, lower or upper case. The user must write it
// with csr_wr_en only while no unit is in flight; the block does not check it.
// Reset clears the decode state, empties the queue and output register, and
// sets the case mode to no change.
module utf8_stream_decoder_case_fold
   import u8cf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_code_unit,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_seq_length,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data
);

   logic           [1:0] case_mode_ff;
   logic           push;
   logic           pop;
   unit_type       push_data;
   unit_type       pop_data;
   queue_ctrl_type ctrl;

   always_ff @(posedge clock) begin
      if (reset) begin
         case_mode_ff <= CASE_NONE;
      end else if (csr_wr_en) begin
         case_mode_ff <= csr_wr_data;
      end
   end

   u8cf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .queue_full  (ctrl.full),
      .push        (push),
      .push_data   (push_data)
   );

   u8cf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .ctrl      (ctrl),
      .pop_data  (pop_data)
   );

   u8cf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .case_mode      (case_mode_ff),
      .ctrl           (ctrl),
      .pop_data       (pop_data),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_code_unit  (rsp_code_unit),
      .rsp_status     (rsp_status),
      .rsp_seq_length (rsp_seq_length)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && ctrl.full && !pop))
      else $error("Unit written into a full queue.");

   a_pop_only_when_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> ctrl.valid)
      else $error("Unit read from an empty queue.");

   a_error_is_star: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |->
         (rsp_code_unit == STAR_UNIT && rsp_seq_length == 2'd1))
      else $error("Error transfer without a single-byte star unit.");

   a_ascii_stays_ascii: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_OK && rsp_seq_length == 2'd1) |->
         (rsp_code_unit[15:7] == 9'd0))
      else $error("Single-byte unit left the ASCII range.");

endmodule

>>> dv/tb.sv
// Self-checking testbench for the UTF-8 stream decoder with Latin case mapping.
module tb;
   import u8cf_pkg::*;

   localparam logic [7:0]  ASCII_HI      = 8'h7F;
   localparam logic [7:0]  LEAD2_LO      = 8'hC0;
   localparam logic [7:0]  LEAD3_LO      = 8'hE0;
   localparam logic [7:0]  WIDE_LO       = 8'hF0;
   localparam logic [7:0]  WIDE_HI       = 8'hFD;
   localparam logic [15:0] CONT_BASE     = 16'h0080;
   localparam logic [15:0] Y_DIAER_UPPER = 16'h0178;
   localparam logic [15:0] Y_DIAER_LOWER = 16'h00FF;
   localparam logic [1:0]  CASE_SPARE    = 2'd3;
   localparam int          PHASE_BYTES   = 180;
   localparam int          DRAIN_CYCLES  = 6;
   localparam int          QUIET_LIMIT   = 2000;

   typedef struct packed {
      bit         mode_write;
      logic [7:0] data;
      bit         known;
      unit_type   want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_in_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_code_unit;
   logic [1:0]  rsp_status;
   logic [1:0]  rsp_seq_length;
   logic        csr_wr_en;
   logic [1:0]  csr_wr_data;

   logic [1:0]  fold_mode;
   logic [1:0]  pend_bytes;
   logic [15:0] part_unit;
   logic [1:0]  seq_total;

   unit_type     unit_queue [$];
   unit_type     next_unit;
   unit_type     want_unit;
   unit_type     typed_want;
   bit           typed_on;
   bit           made_unit;
   stim_row_type script [$];
   int           send_idle_pct;
   int           stall_pct;
   int           bytes_sent;
   int           quiet_cycles;
   int           err_count;

   utf8_stream_decoder_case_fold dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_code_unit  (rsp_code_unit),
      .rsp_status     (rsp_status),
      .rsp_seq_length (rsp_seq_length),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic logic [15:0] fold_case(input logic [15:0] u, input logic [1:0] m);
      bit odd_u;
      bit pair_even;
      bit pair_odd;
      odd_u     = u[0];
      pair_even = (u >= 16'h0100 && u <= 16'h0137) || (u >= 16'h014A && u <= 16'h0177);
      pair_odd  = (u >= 16'h0139 && u <= 16'h0148) || (u >= 16'h0179 && u <= 16'h017E);
      if (m == CASE_LOWER) begin
         if ((u >= 16'h0041 && u <= 16'h005A) || (u >= 16'h00C0 && u <= 16'h00DE))
            return u + 16'h0020;
         if ((pair_even && !odd_u) || (pair_odd && odd_u))
            return u + 16'd1;
         if (u == Y_DIAER_UPPER)
            return Y_DIAER_LOWER;
      end else if (m == CASE_UPPER) begin
         if ((u >= 16'h0061 && u <= 16'h007A) || (u >= 16'h00E0 && u <= 16'h00FE))
            return u - 16'h0020;
         if ((pair_even && odd_u) || (pair_odd && !odd_u))
            return u - 16'd1;
         if (u == Y_DIAER_LOWER)
            return Y_DIAER_UPPER;
      end
      return u;
   endfunction

   function automatic bit decode_byte(input logic [7:0] b, output unit_type r);
      r            = '0;
      r.status     = STATUS_OK;
      r.seq_length = 2'd1;
      if (pend_bytes != 2'd0) begin
         part_unit  = part_unit * 16'd64 + {8'h00, b} - CONT_BASE;
         pend_bytes = pend_bytes - 2'd1;
         if (pend_bytes != 2'd0)
            return 1'b0;
         r.code_unit  = fold_case(part_unit, fold_mode);
         r.seq_length = seq_total;
         return 1'b1;
      end
      seq_total = 2'd1;
      if (b <= ASCII_HI) begin
         r.code_unit = fold_case({8'h00, b}, fold_mode);
         return 1'b1;
      end
      if (b >= LEAD2_LO && b < LEAD3_LO) begin
         part_unit  = {8'h00, b - LEAD2_LO};
         pend_bytes = 2'd1;
         seq_total  = 2'd2;
         return 1'b0;
      end
      if (b >= LEAD3_LO && b < WIDE_LO) begin
         part_unit  = {8'h00, b - LEAD3_LO};
         pend_bytes = 2'd2;
         seq_total  = 2'd3;
         return 1'b0;
      end
      r.code_unit = fold_case(STAR_UNIT, fold_mode);
      r.status    = (b >= WIDE_LO && b <= WIDE_HI) ? STATUS_WIDE : STATUS_INVALID;
      return 1'b1;
   endfunction

   function automatic stim_row_type byte_row(input logic [7:0] d);
      stim_row_type r;
      r      = '0;
      r.data = d;
      return r;
   endfunction

   function automatic stim_row_type known_row(input logic [7:0] d, input logic [15:0] cu,
                                              input status_type st, input logic [1:0] len);
      stim_row_type r;
      r                 = byte_row(d);
      r.known           = 1'b1;
      r.want.code_unit  = cu;
      r.want.status     = st;
      r.want.seq_length = len;
      return r;
   endfunction

   function automatic stim_row_type mode_row(input logic [1:0] m);
      stim_row_type r;
      r            = '0;
      r.mode_write = 1'b1;
      r.data       = {6'd0, m};
      return r;
   endfunction

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic drain_units();
      req_valid <= 1'b0;
      do @(negedge clock); while (unit_queue.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_case_mode(input logic [1:0] m);
      drain_units();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic send_random_char();
      int          pick;
      logic [15:0] u;
      pick = $urandom_range(99);
      if (pick < 35) begin
         send_byte(8'($urandom_range(127)));
      end else if (pick < 65) begin
         if ($urandom_range(1) == 1)
            u = 16'($urandom_range(16'h017F, 16'h00C0));
         else
            u = 16'($urandom_range(16'h07FF, 0));
         send_byte({3'b110, u[10:6]});
         send_byte({2'b10, u[5:0]});
      end else if (pick < 85) begin
         if ($urandom_range(3) == 0)
            u = 16'($urandom_range(16'h017F, 0));
         else
            u = 16'($urandom);
         send_byte({4'b1110, u[15:12]});
         send_byte({2'b10, u[11:6]});
         send_byte({2'b10, u[5:0]});
      end else begin
         // A stray byte of any value gives wide and invalid leads and broken sequences.
         send_byte(8'($urandom));
      end
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (reset) begin
         fold_mode    = CASE_NONE;
         pend_bytes   = 2'd0;
         part_unit    = 16'd0;
         seq_total    = 2'd0;
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (req_valid && !req_stall) begin
            quiet_cycles = 0;
            made_unit    = decode_byte(req_in_byte, next_unit);
            if (typed_on)
               next_unit = typed_want;
            if (made_unit)
               unit_queue = {unit_queue, next_unit};
         end
         if (csr_wr_en) begin
            quiet_cycles = 0;
            fold_mode    = csr_wr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            quiet_cycles = 0;
            if (unit_queue.size() == 0) begin
               err_count++;
               if (err_count <= 10)
                  $display("unexpected transfer: unit %h status %0d length %0d",
                           rsp_code_unit, rsp_status, rsp_seq_length);
            end else begin
               want_unit = unit_queue.pop_front();
               if (rsp_code_unit !== want_unit.code_unit || rsp_status !== want_unit.status ||
                   rsp_seq_length !== want_unit.seq_length) begin
                  err_count++;
                  if (err_count <= 10)
                     $display("mismatch: expected %h/%0d/%0d got %h/%0d/%0d",
                              want_unit.code_unit, want_unit.status, want_unit.seq_length,
                              rsp_code_unit, rsp_status, rsp_seq_length);
               end
            end
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      int         phase_end;
      bit         paused;
      logic [1:0] phase_mode;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_in_byte   = 8'h00;
      rsp_stall     = 1'b0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = CASE_NONE;
      typed_on      = 1'b0;
      typed_want    = '0;
      bytes_sent    = 0;
      err_count     = 0;
      send_idle_pct = 33;
      stall_pct     = 87;
      script = '{
         known_row(8'h00, 16'h0000, STATUS_OK, 2'd1),
         known_row(8'h7F, 16'h007F, STATUS_OK, 2'd1),
         known_row(8'h80, STAR_UNIT, STATUS_INVALID, 2'd1),
         known_row(8'hBF, STAR_UNIT, STATUS_INVALID, 2'd1),
         known_row(8'hFE, STAR_UNIT, STATUS_INVALID, 2'd1),
         known_row(8'hFF, STAR_UNIT, STATUS_INVALID, 2'd1),
         known_row(8'hF0, STAR_UNIT, STATUS_WIDE, 2'd1),
         known_row(8'hFD, STAR_UNIT, STATUS_WIDE, 2'd1),
         byte_row(8'hC0), byte_row(8'h80),
         byte_row(8'hDF), byte_row(8'hBF),
         byte_row(8'hEF), byte_row(8'hFF), byte_row(8'h00),
         mode_row(CASE_LOWER),
         byte_row(8'h41),
         byte_row(8'hC5), byte_row(8'hB8),
         known_row(8'hF5, STAR_UNIT, STATUS_WIDE, 2'd1),
         mode_row(CASE_UPPER),
         byte_row(8'h7A),
         byte_row(8'hC3), byte_row(8'hBF),
         mode_row(CASE_SPARE),
         byte_row(8'h61),
         byte_row(8'hC3), mode_row(CASE_LOWER), byte_row(8'h80),
         mode_row(CASE_NONE)
      };
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].mode_write) begin
            write_case_mode(script[i].data[1:0]);
         end else begin
            typed_on   = script[i].known;
            typed_want = script[i].want;
            send_byte(script[i].data);
         end
      end
      typed_on = 1'b0;

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 33;
               stall_pct     = 87;
               phase_mode    = CASE_LOWER;
            end
            1: begin
               send_idle_pct = 87;
               stall_pct     = 33;
               phase_mode    = CASE_UPPER;
            end
            default: begin
               send_idle_pct = 0;
               stall_pct     = 0;
               phase_mode    = CASE_NONE;
            end
         endcase
         write_case_mode(phase_mode);
         phase_end = bytes_sent + PHASE_BYTES;
         paused    = 1'b0;
         while (bytes_sent < phase_end) begin
            if (!paused && bytes_sent >= phase_end - PHASE_BYTES / 2) begin
               drain_units();
               paused = 1'b1;
            end
            send_random_char();
         end
      end

      drain_units();
      if (err_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
